/* hdl/assert_macros.svh */
// Assertion macros used by the unit prefix scaler RTL.
// Depends on: nothing; expects clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a condition at every rising clock edge outside reset
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// check that an antecedent implies a consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/ups_pkg.sv */
// Package for the unit prefix scaler: constants, microcode word types and program table.
// Depends on: nothing.
`timescale 1ns / 1ps
package ups_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int WHOLE_W        = 10;
  localparam int UNIT_W         = 2;
  localparam int DIGIT_W        = 2;
  localparam int FRAC_W         = 7;
  localparam int DIV_W          = 11;
  localparam int BITS_PER_CYCLE = 8;

  localparam logic [DIV_W-1:0] STEP_DEC = 11'd1000;
  localparam logic [DIV_W-1:0] STEP_BIN = 11'd1024;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SETUP,
    OP_DIV,
    OP_POST,
    OP_FRAC,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_LT_STEP,
    COND_MORE,
    COND_HALT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t PC_TEST = 3'd0;
  localparam pc_t PC_DIV  = 3'd1;
  localparam pc_t PC_POST = 3'd2;
  localparam pc_t PC_FRAC = 3'd3;
  localparam pc_t PC_EMIT = 3'd4;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_TEST: w = '{op: OP_SETUP, cond: COND_LT_STEP, target: PC_FRAC};
      PC_DIV:  w = '{op: OP_DIV,   cond: COND_MORE,    target: PC_DIV};
      PC_POST: w = '{op: OP_POST,  cond: COND_JUMP,    target: PC_TEST};
      PC_FRAC: w = '{op: OP_FRAC,  cond: COND_NEXT,    target: PC_EMIT};
      PC_EMIT: w = '{op: OP_EMIT,  cond: COND_HALT,    target: PC_TEST};
      default: w = '{op: OP_NONE,  cond: COND_HALT,    target: PC_TEST};
    endcase
    return w;
  endfunction

endpackage

/* hdl/unit_prefix_scaler.sv */
// Unit prefix scaler: microcoded sequencer over a long-division datapath.
// Depends on: ups_pkg, assert_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low; amount and mode are sampled at that edge. busy stays high until the
//   result is out.
//   Result channel: done is high for exactly one cycle with whole_part,
//   unit_index, digit_count and fraction_shown valid; the receiver cannot stall,
//   so the result must be taken in that cycle.
//   Each divide step runs the microcode loop of test, NCH divide passes and
//   commit, where NCH = ceil(VALUE_BITS / 8) (4 at 31 bits); the loop repeats
//   while the value is not below the step, then the fraction and emit steps
//   follow. The divide unit resolves 8 quotient bits per cycle.
//   A new command may be taken in the cycle done is high.
//   Reset: synchronous, active high; clears busy and done, the sequencer returns
//   to its first step.
module unit_prefix_scaler
  import ups_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] amount,
  input  logic                  mode,
  output logic                  done,
  output logic [WHOLE_W-1:0]    whole_part,
  output logic [UNIT_W-1:0]     unit_index,
  output logic [DIGIT_W-1:0]    digit_count,
  output logic [FRAC_W-1:0]     fraction_shown
);

  `include "assert_macros.svh"

  localparam int NCH  = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int DW   = NCH * BITS_PER_CYCLE;
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CMPW = (VALUE_BITS > DIV_W) ? VALUE_BITS : DIV_W;
  localparam logic [CW-1:0] CHUNK_LAST = CW'(NCH - 1);

  pc_t                   pc;
  pc_t                   pc_next;
  logic                  busy_next;
  ucode_t                uw;
  logic                  bin;
  logic [VALUE_BITS-1:0] val;
  logic [WHOLE_W-1:0]    rem;
  logic [UNIT_W-1:0]     steps;
  logic                  scaled;
  logic [DW-1:0]         quo;
  logic [WHOLE_W-1:0]    part;
  logic [CW-1:0]         chunk;
  logic [WHOLE_W-1:0]    thou;
  logic [DIV_W-1:0]      divisor;
  logic                  val_lt_step;
  logic [DIV_W-1:0]      p_w;
  logic [DW-1:0]         q_w;
  logic [19:0]           prod_bin;
  logic [20:0]           prod10;
  logic [15:0]           prod100;
  logic                  accept;

  assign accept      = start && !busy;
  assign uw          = ucode_rom(pc);
  assign divisor     = bin ? STEP_BIN : STEP_DEC;
  assign val_lt_step = CMPW'(val) < CMPW'(divisor);
  assign prod_bin    = 20'(rem) * 20'd1000;
  assign prod10      = 21'(thou) * 21'd205;
  assign prod100     = 16'(thou) * 16'd41;

  always_comb begin
    p_w = DIV_W'(part);
    q_w = quo;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      p_w = {p_w[DIV_W-2:0], q_w[DW-1]};
      q_w = {q_w[DW-2:0], 1'b0};
      if (p_w >= divisor) begin
        p_w    = p_w - divisor;
        q_w[0] = 1'b1;
      end
    end
  end

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (busy) begin
      case (uw.cond)
        COND_NEXT:    pc_next = pc + pc_t'(1);
        COND_JUMP:    pc_next = uw.target;
        COND_LT_STEP: pc_next = val_lt_step ? uw.target : pc + pc_t'(1);
        COND_MORE:    pc_next = (chunk != CHUNK_LAST) ? uw.target : pc + pc_t'(1);
        COND_HALT: begin
          pc_next   = PC_TEST;
          busy_next = 1'b0;
        end
        default: begin
          pc_next   = PC_TEST;
          busy_next = 1'b0;
        end
      endcase
    end else if (accept) begin
      pc_next   = PC_TEST;
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_TEST;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
      done <= busy && (uw.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val    <= amount;
      bin    <= mode;
      rem    <= '0;
      steps  <= '0;
      scaled <= 1'b0;
    end else if (busy) begin
      case (uw.op)
        OP_SETUP: begin
          quo   <= DW'(val);
          part  <= '0;
          chunk <= '0;
        end
        OP_DIV: begin
          quo   <= q_w;
          part  <= p_w[WHOLE_W-1:0];
          chunk <= chunk + CW'(1);
        end
        OP_POST: begin
          val    <= quo[VALUE_BITS-1:0];
          rem    <= part;
          steps  <= steps + UNIT_W'(1);
          scaled <= 1'b1;
        end
        OP_FRAC: begin
          thou <= bin ? prod_bin[19:10] : rem;
        end
        OP_EMIT: begin
          whole_part <= val[WHOLE_W-1:0];
          unit_index <= steps;
          if (!scaled || CMPW'(val) >= CMPW'(100)) begin
            digit_count    <= 2'd0;
            fraction_shown <= '0;
          end else if (CMPW'(val) >= CMPW'(10)) begin
            digit_count    <= 2'd1;
            fraction_shown <= FRAC_W'(prod100[15:12]);
          end else begin
            digit_count    <= 2'd2;
            fraction_shown <= prod10[17:11];
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
  `ASSERT_SAME(a_done_after_run, $fell(busy), done, "busy dropped without a result")
  `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
  `ASSERT_SAME(a_digits_range, done, digit_count != 2'd3, "digit count out of range")
  `ASSERT_SAME(a_div_quotient_fits, busy && (uw.op == OP_POST),
               val_lt_step == 1'b0, "divide committed below one step")

endmodule

/* tb/unit_prefix_scaler_checker.sv */
// Checker for the unit prefix scaler: predicts each scaled result and compares it
// with the done strobe. Depends on: ups_pkg.
`timescale 1ns / 1ps
module unit_prefix_scaler_checker
  import ups_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VALUE_BITS-1:0] amount,
  input  logic                  mode,
  input  logic                  done,
  input  logic [WHOLE_W-1:0]    whole_part,
  input  logic [UNIT_W-1:0]     unit_index,
  input  logic [DIGIT_W-1:0]    digit_count,
  input  logic [FRAC_W-1:0]     fraction_shown,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic [WHOLE_W-1:0] whole;
    logic [UNIT_W-1:0]  unit;
    logic [DIGIT_W-1:0] digits;
    logic [FRAC_W-1:0]  frac;
  } scaled_t;

  scaled_t expected_scaled[$];
  scaled_t want;
  int      mismatches = 0;
  int      outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic scaled_t scale_amount(input logic [VALUE_BITS-1:0] amt,
                                           input logic bin);
    longint unsigned val;
    longint unsigned step;
    longint unsigned rem;
    longint unsigned steps;
    longint unsigned shown;
    longint unsigned digits;
    scaled_t         r;
    val   = 64'(amt);
    step  = 64'(bin ? STEP_BIN : STEP_DEC);
    rem   = 0;
    steps = 0;
    while (val >= step) begin
      rem   = val % step;
      val   = val / step;
      steps = steps + 1;
    end
    if (bin)
      rem = rem * 1000 / 1024;
    if (val >= 100 || steps == 0) begin
      digits = 0;
      shown  = 0;
    end else if (val >= 10) begin
      digits = 1;
      shown  = rem / 100;
    end else begin
      digits = 2;
      shown  = rem / 10;
    end
    r.whole  = val[WHOLE_W-1:0];
    r.unit   = steps[UNIT_W-1:0];
    r.digits = digits[DIGIT_W-1:0];
    r.frac   = shown[FRAC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_scaled.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (expected_scaled.size() == 0) begin
          $error("done strobe with no transaction pending");
          mismatches++;
        end else begin
          want = expected_scaled.pop_front();
          if (whole_part !== want.whole) begin
            $error("whole_part: expected %0d, actual %0d", want.whole, whole_part);
            mismatches++;
          end
          if (unit_index !== want.unit) begin
            $error("unit_index: expected %0d, actual %0d", want.unit, unit_index);
            mismatches++;
          end
          if (digit_count !== want.digits) begin
            $error("digit_count: expected %0d, actual %0d", want.digits, digit_count);
            mismatches++;
          end
          if (fraction_shown !== want.frac) begin
            $error("fraction_shown: expected %0d, actual %0d", want.frac,
                   fraction_shown);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_scaled.push_back(scale_amount(amount, mode));
      outstanding <= expected_scaled.size();
    end
  end

endmodule

/* tb/unit_prefix_scaler_tb.sv */
// Testbench top for the unit prefix scaler: clock, reset, directed and random
// commands with idle bursts, watchdog and verdict. Depends on: ups_pkg,
// unit_prefix_scaler, unit_prefix_scaler_checker.
`timescale 1ns / 1ps
module unit_prefix_scaler_tb;
  import ups_pkg::*;

  localparam int VB             = VALUE_BITS_DEF;
  localparam int NUM_RANDOM     = 1030;
  localparam int QUIET_TAIL     = 150;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int NUM_DIRECTED   = 25;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VB-1:0]      amount = '0;
  logic               mode = 1'b0;
  logic               busy;
  logic               done;
  logic [WHOLE_W-1:0] whole_part;
  logic [UNIT_W-1:0]  unit_index;
  logic [DIGIT_W-1:0] digit_count;
  logic [FRAC_W-1:0]  fraction_shown;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  int unsigned dir_amount[NUM_DIRECTED] = '{
    0, 0, 999, 1023, 1000, 1024, 1999, 2047, 5000, 10239, 10000, 10240,
    99999, 102399, 100000, 102400, 999999, 1048575, 1000000, 1048576,
    1000000000, 1073741824, 2147483647, 2147483647, 123456789
  };
  bit dir_mode[NUM_DIRECTED] = '{
    0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1,
    0, 1, 0, 1, 0, 1, 0, 1,
    0, 1, 0, 1, 0
  };

  always #5 clk = ~clk;

  unit_prefix_scaler #(.VALUE_BITS(VB)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .amount        (amount),
    .mode          (mode),
    .done          (done),
    .whole_part    (whole_part),
    .unit_index    (unit_index),
    .digit_count   (digit_count),
    .fraction_shown(fraction_shown)
  );

  unit_prefix_scaler_checker #(.VALUE_BITS(VB)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .amount        (amount),
    .mode          (mode),
    .done          (done),
    .whole_part    (whole_part),
    .unit_index    (unit_index),
    .digit_count   (digit_count),
    .fraction_shown(fraction_shown),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_transaction(input logic [VB-1:0] a, input logic m);
    start  <= 1'b1;
    amount <= a;
    mode   <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [VB-1:0] pick_amount(input logic m);
    longint unsigned step;
    longint unsigned scale;
    longint unsigned v;
    int              k;
    int              bitlen;
    int unsigned     wholes[8] = '{1, 9, 10, 11, 99, 100, 101, 999};
    step = 64'(m ? STEP_BIN : STEP_DEC);
    case ($urandom_range(0, 9))
      0: v = 64'($urandom_range(0, 2047));
      1, 2, 3, 4, 5, 6: begin
        bitlen = $urandom_range(1, VB);
        v = longint'($urandom) & ((64'd1 << bitlen) - 1);
      end
      7, 8: begin
        k = $urandom_range(1, 3);
        scale = 1;
        repeat (k) scale = scale * step;
        v = wholes[$urandom_range(0, 7)] * scale;
        if ($urandom_range(0, 3) != 0)
          v = v + (longint'($urandom) % scale);
      end
      default: v = 64'($urandom);
    endcase
    return v[VB-1:0];
  endfunction

  initial begin
    bit            idle_on;
    logic          m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_transaction(dir_amount[i][VB-1:0], dir_mode[i]);
      if (i % 7 == 3)
        hold_sender($urandom_range(1, 8));
    end
    idle_on = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 50 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if (i == 400)
        drain_results();
      m = 1'($urandom_range(0, 1));
      send_transaction(pick_amount(m), m);
      if (i < NUM_RANDOM - QUIET_TAIL && idle_on && $urandom_range(0, 3) == 0)
        hold_sender($urandom_range(1, 8));
    end
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
